// ===== rtl/lfpf_pkg.sv =====
package lfpf_pkg;

  localparam int SAMPLE_W  = 14;
  localparam int ADC_W     = 12;
  localparam int COEFF_W   = 24;
  localparam int GAIN_W    = 8;
  localparam int SHIFT_W   = 4;
  localparam int TAP_W     = 18;
  localparam int N_TAPS    = 5;
  localparam int WGT_W     = 7;
  localparam int FILT_SHIFT = 6;
  localparam int PROD_W    = TAP_W + 1 + WGT_W;
  localparam int TERM_W    = PROD_W - FILT_SHIFT;
  localparam int SUM_W     = 22;
  localparam int PEAK_W    = 10;
  localparam int AMP_W     = 12;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef logic [TAP_W-1:0]        tap_t;
  typedef logic signed [WGT_W-1:0] wgt_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // partial sum walking down the row of tap cells
  typedef struct packed {
    logic vld;
    sum_t sum;
  } chain_tok_t;

  // newest tap first, oldest (leaving the delay line) last
  localparam wgt_t TAP_WEIGHT [N_TAPS] = '{
    7'sd24, 7'sd31, 7'sd16, -7'sd35, -7'sd36
  };

  localparam tap_t FILT_MAX = 18'h3FFFF;
  localparam sum_t FILT_MAX_S = sum_t'($signed({1'b0, FILT_MAX}));
  localparam logic [AMP_W-1:0] AMP_MAX = 12'hFFF;

endpackage

// ===== rtl/lfpf_lin.sv =====
module lfpf_lin
  import lfpf_pkg::*;
(
  input  logic [ADC_W-1:0]   adc,
  input  logic [COEFF_W-1:0] coeff,
  output tap_t               lin
);

  logic [GAIN_W-1:0]          gain;
  logic [SHIFT_W-1:0]         fill_shift;
  logic [ADC_W-1:0]           pedestal;
  logic [ADC_W:0]             diff;
  logic [ADC_W+GAIN_W-1:0]    prod;

  assign gain       = coeff[COEFF_W-1 -: GAIN_W];
  assign fill_shift = coeff[ADC_W +: SHIFT_W];
  assign pedestal   = coeff[ADC_W-1:0];
  assign diff       = {1'b0, adc} - {1'b0, pedestal};
  assign prod       = diff[ADC_W-1:0] * gain;

  always_comb begin
    if (gain == '0) begin
      // zero gain kills the whole word
      lin = '0;
    end else if (diff[ADC_W]) begin
      lin = tap_t'({fill_shift, {ADC_W{1'b0}}});
    end else begin
      lin = prod[2 +: TAP_W];
    end
  end

endmodule

// ===== rtl/lfpf_tap_cell.sv =====
module lfpf_tap_cell
  import lfpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  tap_t       tap_in,
  input  wgt_t       weight,
  input  chain_tok_t tok_in,
  output tap_t       tap_out,
  output chain_tok_t tok_out
);

  tap_t                      tap_r;
  chain_tok_t                tok_r;
  logic signed [TAP_W:0]     tap_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [TERM_W-1:0]  term;

  assign tap_s = $signed({1'b0, tap_r});
  assign prod  = tap_s * weight;
  // arithmetic drop of the low bits is a floor divide
  assign term  = prod[PROD_W-1:FILT_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r     <= '0;
      tok_r.vld <= 1'b0;
    end else begin
      if (shift_en) begin
        tap_r <= tap_in;
      end
      tok_r.vld <= tok_in.vld;
    end
    tok_r.sum <= tok_in.sum + sum_t'(term);
  end

  assign tap_out = tap_r;
  assign tok_out = tok_r;

endmodule

// ===== rtl/linearize_fir_peak_finder.sv =====
// Linearizing FIR peak finder. Each request on the in_ channel carries one
// 14-bit raw sample; only its low 12 bits are used. The sample is linearized
// with the coefficient word (pedestal, negative-fill shift, gain), pushed into
// a five-tap delay line built as a row of tap cells with weights
// 24, 31, 16, -35, -36, and filtered. Every input request produces exactly one
// out_ request: the previous filter value (saturated to 0xFFF, then >> 2) when
// it is above both neighbors, else 0. A new request is taken only once the
// previous one has finished, which waits for a free output register. After
// the sample is taken the partial sum walks through the five tap cells at one
// cell a cycle, is latched, and then gives the filter value and peak decision.
// A finished result sits in the output register while the next sample is
// already being worked on; a held output only stalls the final step. Write
// the coefficient word on cfg_ only while no request is in flight; reset
// clears it, the delay line and the filter history to zero.
module linearize_fir_peak_finder
  import lfpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COEFF_W-1:0]    cfg_data,    // [11:0] pedestal, [15:12] fill shift, [23:16] gain
  // sample stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // [13:0] sample, [15:14] zero
  // peak stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata    // [9:0] peak_amplitude, [15:10] zero
);

  logic [COEFF_W-1:0] coeff_r;
  logic               busy_r;
  logic               start_r;
  logic               acc_v_r;
  sum_t               acc_r;
  tap_t               hist0_r;
  tap_t               hist1_r;
  logic               out_vld_r;
  logic [PEAK_W-1:0]  out_pk_r;

  logic               accept;
  logic               fin;
  tap_t               lin;
  tap_t               filt;
  tap_t               oldest;
  logic [AMP_W-1:0]   amp;
  logic [PEAK_W-1:0]  pk;

  tap_t               tap_q [N_TAPS];
  chain_tok_t         tok_q [N_TAPS];

  // coefficient register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
    end else if (cfg_valid) begin
      coeff_r <= cfg_data;
    end
  end

  // one sample in flight at a time
  assign in_tready = !busy_r;
  assign accept    = in_tvalid && !busy_r;

  lfpf_lin u_lin (
    .adc   (in_tdata[ADC_W-1:0]),
    .coeff (coeff_r),
    .lin   (lin)
  );

  // row of tap cells: each shifts its tap to the next on accept and adds its
  // weighted tap to the partial sum passing through
  for (genvar k = 0; k < N_TAPS; k++) begin : g_cell
    tap_t       tap_in_k;
    chain_tok_t tok_in_k;

    if (k == 0) begin : g_head
      assign tap_in_k = lin;
      assign tok_in_k = '{vld: start_r, sum: '0};
    end else begin : g_body
      assign tap_in_k = tap_q[k-1];
      assign tok_in_k = tok_q[k-1];
    end

    lfpf_tap_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .tap_in   (tap_in_k),
      .weight   (TAP_WEIGHT[k]),
      .tok_in   (tok_in_k),
      .tap_out  (tap_q[k]),
      .tok_out  (tok_q[k])
    );
  end

  // last cell holds the sample that just left the delay line
  assign oldest = tap_q[N_TAPS-1];

  // filter value: floor at zero, zero when the oldest tap is empty, clamp
  always_comb begin
    priority if (acc_r < 0 || oldest == '0) begin
      filt = '0;
    end else if (acc_r > FILT_MAX_S) begin
      filt = FILT_MAX;
    end else begin
      filt = acc_r[TAP_W-1:0];
    end
  end

  // peak test on the previous filter value
  assign amp = (hist0_r > tap_t'(AMP_MAX)) ? AMP_MAX : hist0_r[AMP_W-1:0];
  assign pk  = (hist0_r > filt && hist0_r > hist1_r) ? amp[AMP_W-1 -: PEAK_W] : '0;

  // finish once the output register is free or being emptied
  assign fin = acc_v_r && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      start_r   <= 1'b0;
      acc_v_r   <= 1'b0;
      hist0_r   <= '0;
      hist1_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      start_r <= accept;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (fin) begin
        busy_r <= 1'b0;
      end
      if (tok_q[N_TAPS-1].vld) begin
        acc_v_r <= 1'b1;
      end else if (fin) begin
        acc_v_r <= 1'b0;
      end
      if (fin) begin
        hist1_r   <= hist0_r;
        hist0_r   <= filt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (tok_q[N_TAPS-1].vld) begin
      acc_r <= tok_q[N_TAPS-1].sum;
    end
    if (fin) begin
      out_pk_r <= pk;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'(out_pk_r);

`ifndef ASSERT_OFF
  // only one partial sum is ever in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({start_r, tok_q[0].vld, tok_q[1].vld, tok_q[2].vld,
              tok_q[3].vld, tok_q[4].vld, acc_v_r}))
    else $error("more than one partial sum in flight");

  // any sum in flight belongs to an accepted sample
  a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (start_r || tok_q[N_TAPS-1].vld || acc_v_r) |-> busy_r)
    else $error("partial sum present while idle");

  // an accepted sample makes the block busy and starts the cell row
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && start_r)
    else $error("accepted sample did not start the cell row");

  // finishing always leaves a result in the output register
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_tvalid && !busy_r && !acc_v_r)
    else $error("finish did not hand over the result");
`endif

endmodule

// ===== test/lfpf_checker.sv =====
module lfpf_checker
  import lfpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [COEFF_W-1:0]    cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // [13:0] sample, [15:14] zero
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,   // [9:0] peak_amplitude, [15:10] zero
  output int                    mismatches,
  output int                    peaks_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WEIGHT [N_TAPS] = '{24, 31, 16, -35, -36};
  localparam int MAX_SHOWN = 10;

  logic [COEFF_W-1:0] coeff_word;
  tap_t               delay_line [4];
  tap_t               filt_hist [2];
  logic [PEAK_W-1:0]  expected_peaks [$];

  // one sample in, one peak word out; advances the delay line and history
  function automatic logic [PEAK_W-1:0] predict_peak(input logic [ADC_W-1:0] adc);
    logic [COEFF_W-1:0] cw;
    int                 diff;
    int                 j;
    tap_t               lin;
    tap_t               oldest;
    tap_t               filt;
    longint             acc;
    logic [AMP_W-1:0]   amp;
    logic [PEAK_W-1:0]  peak;
    cw = coeff_word;
    if (cw[23:16] == '0) cw = '0;
    diff = int'(adc) - int'(cw[11:0]);
    if (diff < 0) lin = tap_t'({cw[15:12], 12'h000});
    else lin = tap_t'((diff * int'(cw[23:16])) >> 2);
    oldest = delay_line[3];
    delay_line[3] = delay_line[2];
    delay_line[2] = delay_line[1];
    delay_line[1] = delay_line[0];
    delay_line[0] = lin;
    // >>> on a signed product floors, as the hardware's shifted terms do
    acc = (longint'(oldest) * WEIGHT[4]) >>> FILT_SHIFT;
    for (j = 3; j >= 0; j--) acc += (longint'(delay_line[j]) * WEIGHT[j]) >>> FILT_SHIFT;
    if (acc < 0 || oldest == '0) filt = '0;
    else if (acc > longint'(FILT_MAX)) filt = FILT_MAX;
    else filt = tap_t'(acc);
    peak = '0;
    if (filt_hist[0] > filt && filt_hist[0] > filt_hist[1]) begin
      amp = (filt_hist[0] > tap_t'(AMP_MAX)) ? AMP_MAX : filt_hist[0][AMP_W-1:0];
      peak = amp[AMP_W-1:2];
    end
    filt_hist[1] = filt_hist[0];
    filt_hist[0] = filt;
    return peak;
  endfunction

  always @(posedge clk) begin
    logic [PEAK_W-1:0] want;
    logic [PEAK_W-1:0] got;
    if (!rst_n) begin
      coeff_word = '0;
      delay_line = '{default: '0};
      filt_hist  = '{default: '0};
      expected_peaks.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) coeff_word = cfg_data;
      // a result can never belong to a sample taken at the same edge
      if (out_tvalid && out_tready) begin
        got = out_tdata[PEAK_W-1:0];
        if (expected_peaks.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: peak_amplitude %0d with no sample pending", $time, got);
        end else begin
          want = expected_peaks.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("%0t: peak_amplitude expected %0d actual %0d", $time, want, got);
          end
        end
      end
      if (in_tvalid && in_tready) expected_peaks.push_back(predict_peak(in_tdata[ADC_W-1:0]));
    end
    peaks_pending = expected_peaks.size();
  end

endmodule

// ===== test/tb_linearize_fir_peak_finder.sv =====
module tb_linearize_fir_peak_finder;
  import lfpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // quiet cycles allowed, well above the length of a long receiver hold
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 24;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [COEFF_W-1:0]    cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // [13:0] sample, [15:14] zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [9:0] peak_amplitude, [15:10] zero

  int                    mismatches;
  int                    peaks_pending;

  // idling knobs, percent of cycles; changed between phases
  int                    send_idle = 0;
  int                    recv_stall = 0;
  // set by the stimulus, cleared by the receiver once its hold is over
  bit                    hold_req = 1'b0;
  // last coefficient word written, used to shape pulses around the pedestal
  logic [COEFF_W-1:0]    coeff_now = '0;

  linearize_fir_peak_finder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lfpf_checker peak_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatches    (mismatches),
    .peaks_pending (peaks_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // watchdog: ends the run when no request moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // one sample request; valid stays high afterwards unless the next one idles first
  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(s);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop sending and wait until every peak word has come back
  task automatic drain_peaks();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (peaks_pending != 0) @(posedge clk);
  endtask

  // coefficient write, only issued with the pipeline drained
  task automatic write_coeff(input logic [COEFF_W-1:0] w);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    coeff_now = w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // triangular pulse sitting on the pedestal, with a little noise
  task automatic send_pulse(input int len);
    int ped;
    int amp;
    int half;
    int k;
    int v;
    ped  = int'(coeff_now[11:0]);
    amp  = $urandom_range(4095);
    half = (len / 2 > 0) ? len / 2 : 1;
    for (k = 0; k < len; k++) begin
      v = ped + (amp * ((k <= half) ? k : len - k)) / half + $urandom_range(8) - 4;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      push_sample({2'($urandom_range(3)), 12'(v)});
    end
  endtask

  // mostly pulses, the rest raw noise and flat runs at the pedestal
  task automatic send_random(input int n_items);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = $urandom_range(3, 12);
        send_pulse(len);
        sent += len;
      end else if (pick < 90) begin
        push_sample(SAMPLE_W'($urandom));
        sent++;
      end else begin
        len = $urandom_range(2, 6);
        repeat (len) push_sample({2'($urandom_range(3)), coeff_now[11:0]});
        sent += len;
      end
    end
  endtask

  // random coefficient word; gain forced to zero now and then
  function automatic logic [COEFF_W-1:0] pick_coeff();
    logic [COEFF_W-1:0] w;
    w = COEFF_W'($urandom);
    if ($urandom_range(7) == 0) w[23:16] = '0;
    return w;
  endfunction

  initial begin
    int p;
    int idle_tab [4][2];
    idle_tab = '{'{0, 0}, '{67, 0}, '{0, 67}, '{18, 18}};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficient word: gain zero, everything linearizes to zero
    push_sample(14'h0000);
    push_sample(14'h3FFF);
    push_sample(14'h2AAA);
    push_sample(14'h1555);
    drain_peaks();

    // zero gain also kills pedestal and fill shift
    write_coeff(24'h00FFFF);
    push_sample(14'h0000);
    push_sample(14'h0FFF);
    drain_peaks();

    // full gain, no pedestal: filter clamp, floor at zero, oldest tap zero
    write_coeff(24'hFF0000);
    push_sample(14'h0001);
    push_sample(14'h0FFF);
    push_sample(14'h0FFF);
    push_sample(14'h0FFF);
    push_sample(14'h0001);
    push_sample(14'h0001);
    push_sample(14'h0000);
    push_sample(14'h0FFF);
    drain_peaks();

    // all ones: negative difference fills with shift, zero difference at the top
    write_coeff(24'hFFFFFF);
    push_sample(14'h0000);
    push_sample(14'h0800);
    push_sample(14'h0FFF);
    push_sample(14'h0FFE);
    push_sample(14'h0FFF);
    push_sample(14'h0000);
    drain_peaks();

    // unit gain with a moderate pedestal
    write_coeff(24'h01A064);
    push_sample(14'h0050);
    push_sample(14'h0200);
    push_sample(14'h3064);
    push_sample(14'h0000);
    drain_peaks();

    for (p = 0; p < 4; p++) begin
      send_idle  = idle_tab[p][0];
      recv_stall = idle_tab[p][1];
      repeat (2) begin
        write_coeff(pick_coeff());
        send_random(230);
        drain_peaks();
      end
      if (p == 0) begin
        // hold the output long enough for the block to back up its input
        write_coeff(24'h40_0020);
        hold_req = 1'b1;
        send_random(40);
        drain_peaks();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lfpf_pkg.sv
rtl/lfpf_lin.sv
rtl/lfpf_tap_cell.sv
rtl/linearize_fir_peak_finder.sv
test/lfpf_checker.sv
test/tb_linearize_fir_peak_finder.sv
